// File: src/wtl_pkg.sv
`default_nettype none

package wtl_pkg;

  // Default phase word width; the top level carries it as a parameter.
  localparam int PHASE_BITS_DEF = 32;

  // Sample width and table size shape the constant tables, so they stay fixed here.
  // The table size must be a power of two.
  localparam int SMP_W         = 16;
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int FRAC_W        = 16;

  localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};

  // Wave selector codes.
  localparam logic [2:0] WAVE_SINE    = 3'd0;
  localparam logic [2:0] WAVE_SAW     = 3'd1;
  localparam logic [2:0] WAVE_TRI     = 3'd2;
  localparam logic [2:0] WAVE_PULSE25 = 3'd3;
  localparam logic [2:0] WAVE_SQUARE  = 3'd4;
  localparam logic [2:0] WAVE_PULSE75 = 3'd5;

  // Register map: one word register, index taken from paddr above the byte lanes.
  localparam int         ADDR_W        = 3;
  localparam logic       REG_WAVE_TYPE = 1'b0;

  typedef logic [TABLE_ENTRIES-1:0][SMP_W-1:0] rom_t;

  localparam logic [63:0] ONE_Q30     = 64'd1 << 30;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // sin(r/N * pi/2) in Q30, from a nested series evaluated in integer steps.
  function automatic logic [63:0] quarter_sine(logic [63:0] r);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] acc;
    logic [63:0] t;
    x   = (HALF_PI_Q30 * r + 64'(TABLE_ENTRIES / 2)) / TABLE_ENTRIES;
    x2  = (x * x) >> 30;
    acc = ONE_Q30;
    t   = ((x2 * acc) >> 30) / 156;
    acc = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    t   = ((x2 * acc) >> 30) / 110;
    acc = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    t   = ((x2 * acc) >> 30) / 72;
    acc = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    t   = ((x2 * acc) >> 30) / 42;
    acc = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    t   = ((x2 * acc) >> 30) / 20;
    acc = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    t   = ((x2 * acc) >> 30) / 6;
    acc = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    return (x * acc) >> 30;
  endfunction

  function automatic rom_t build_sine();
    rom_t        rom;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] s;
    longint      mag;
    longint      v;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      m   = 64'(4 * i);
      q   = m / TABLE_ENTRIES;
      r   = m - q * 64'(TABLE_ENTRIES);
      s   = q[0] ? quarter_sine(64'(TABLE_ENTRIES) - r) : quarter_sine(r);
      mag = longint'((s * (64'd1 << (SMP_W - 1)) + (ONE_Q30 >> 1)) >> 30);
      v   = (q >= 64'd2) ? -mag : mag;
      if (v > longint'(SMP_MAX)) v = longint'(SMP_MAX);
      if (v < longint'(SMP_MIN)) v = longint'(SMP_MIN);
      rom[i] = SMP_W'(v);
    end
    return rom;
  endfunction

  // Falling ramp 1 - 2i/N, rounded, with +1.0 clipped to the largest code.
  function automatic rom_t build_saw();
    rom_t        rom;
    logic [63:0] u;
    longint      v;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      u = (64'd1 << SMP_W) * 64'(TABLE_ENTRIES - i);
      v = longint'((64'd2 * u + 64'(TABLE_ENTRIES)) / (2 * TABLE_ENTRIES))
          - (longint'(1) << (SMP_W - 1));
      if (v > longint'(SMP_MAX)) v = longint'(SMP_MAX);
      rom[i] = SMP_W'(v);
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_sine();
  localparam rom_t SAW_ROM  = build_saw();

endpackage

`default_nettype wire

// File: src/wtl_rom.sv
`default_nettype none

module wtl_rom
  import wtl_pkg::*;
(
  input  wire logic [2:0]              wave_type,
  input  wire logic [IDX_W-1:0]        idx,
  output logic signed [SMP_W-1:0]      value
);

  localparam int QW = IDX_W + 3;

  logic [QW-1:0] quad;

  // Pulse tables are high while 4*i stays below four times the duty point times N.
  assign quad = {1'b0, idx, 2'b00};

  always_comb begin
    case (wave_type)
      WAVE_SINE:    value = SINE_ROM[idx];
      WAVE_SAW:     value = SAW_ROM[idx];
      WAVE_TRI:     value = (idx == '0) ? SMP_MAX : SMP_MIN;
      WAVE_PULSE25: value = (quad < QW'(TABLE_ENTRIES)) ? SMP_MAX : SMP_MIN;
      WAVE_SQUARE:  value = (quad < QW'(2 * TABLE_ENTRIES)) ? SMP_MAX : SMP_MIN;
      WAVE_PULSE75: value = (quad < QW'(3 * TABLE_ENTRIES)) ? SMP_MAX : SMP_MIN;
      default:      value = '0;
    endcase
  end

endmodule

`default_nettype wire

// File: src/wtl_interp.sv
`default_nettype none

module wtl_interp
  import wtl_pkg::*;
(
  input  wire logic signed [SMP_W-1:0] left,
  input  wire logic signed [SMP_W-1:0] right,
  input  wire logic [FRAC_W-1:0]       frac,
  output logic signed [SMP_W-1:0]      sample
);

  localparam int ACC_W = SMP_W + FRAC_W + 2;

  logic signed [SMP_W:0]   diff;
  logic signed [ACC_W-1:0] prod;
  logic signed [ACC_W-1:0] base;
  logic signed [ACC_W-1:0] acc;

  // L*(1-f) + R*f is rewritten as L + (R-L)*f so that one multiplier does the work.
  assign diff = $signed({right[SMP_W-1], right}) - $signed({left[SMP_W-1], left});
  assign prod = diff * $signed({1'b0, frac});
  assign base = $signed({{2{left[SMP_W-1]}}, left, {FRAC_W{1'b0}}});

  // Adding one half before the arithmetic shift rounds to nearest, ties upwards.
  assign acc = base + prod + ACC_W'(1 << (FRAC_W - 1));

  // The result lies between the two neighbours, so the upper bits are sign only.
  assign sample = acc[SMP_W+FRAC_W-1:FRAC_W];

endmodule

`default_nettype wire

// File: src/wavetable_interpolating_lookup_top.sv
`default_nettype none

// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   phase  [PHASE_BITS-1:0] unsigned
// output    out        out_valid/out_stall sample [15:0] signed Q1.15
// config    in         APB write/read      wave_type at byte address 0
//
// Each transaction's sample passes through one input register, then table
// reads and one multiply-add into the output register.
// One transaction is accepted every cycle while the output is not stalled.
// A stalled output keeps its sample; the input register still fills behind it.
// Reset is synchronous and clears the valid flags and selects the sine table.
module wavetable_interpolating_lookup_top
  import wtl_pkg::*;
#(
  parameter int PHASE_BITS = PHASE_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,

  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [PHASE_BITS-1:0]   phase,

  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic signed [SMP_W-1:0]      sample,

  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [ADDR_W-1:0]       paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [2:0]             wave_type;
  logic                   s1_valid;
  logic [PHASE_BITS-1:0]  s1_phase;
  logic                   out_adv;
  logic                   s1_load;
  logic                   tri_sel;
  logic [IDX_W-1:0]       left_idx;
  logic [IDX_W-1:0]       right_idx;
  logic [PHASE_BITS-1:0]  frac_word;
  logic [FRAC_W-1:0]      frac;
  logic signed [SMP_W-1:0] left_val;
  logic signed [SMP_W-1:0] right_val;
  logic signed [SMP_W-1:0] sample_next;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_WAVE_TYPE) ? {29'd0, wave_type} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_type <= WAVE_SINE;
    end else if (psel && penable && pwrite && paddr[ADDR_W-1:2] == REG_WAVE_TYPE) begin
      wave_type <= pwdata[2:0];
    end
  end

  // Handshake: the output register moves on when empty or taken.
  assign out_adv  = !out_valid || !out_stall;
  assign s1_load  = !s1_valid || out_adv;
  assign in_stall = s1_valid && !out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_phase <= phase;
    end
  end

  // The triangle table has two entries, every other table TABLE_ENTRIES.
  // Taking the top bits as the index and the rest as the fraction is phase times the table size.
  assign tri_sel   = (wave_type == WAVE_TRI);
  assign left_idx  = tri_sel ? IDX_W'(s1_phase[PHASE_BITS-1])
                             : s1_phase[PHASE_BITS-1 -: IDX_W];
  assign right_idx = tri_sel ? (left_idx ^ IDX_W'(1)) : (left_idx + IDX_W'(1));
  assign frac_word = tri_sel ? {s1_phase[PHASE_BITS-2:0], 1'b0}
                             : {s1_phase[PHASE_BITS-IDX_W-1:0], {IDX_W{1'b0}}};
  assign frac      = frac_word[PHASE_BITS-1 -: FRAC_W];

  wtl_rom u_rom_left (
    .wave_type (wave_type),
    .idx       (left_idx),
    .value     (left_val)
  );

  wtl_rom u_rom_right (
    .wave_type (wave_type),
    .idx       (right_idx),
    .value     (right_val)
  );

  wtl_interp u_interp (
    .left   (left_val),
    .right  (right_val),
    .frac   (frac),
    .sample (sample_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid) begin
      sample <= sample_next;
    end
  end

  // The input side only stalls behind a full, stalled output register.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the output register could move");

  // An accepted transaction is held in the input register on the next cycle.
  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted transaction lost from the input register");

  // A transaction that moves out of a full input register reaches the output.
  a_move_out: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_adv) |=> out_valid)
    else $error("transaction dropped between input and output registers");

  // Unused selector codes give a zero sample.
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_adv && (wave_type > WAVE_PULSE75)) |=> (sample == '0))
    else $error("unused wave selector produced a non-zero sample");

endmodule

`default_nettype wire
